// ----- design/ptt_pkg.sv -----
package ptt_pkg;

    localparam int TIME_W         = 64;
    localparam int PERIOD_W       = 57;
    localparam int KIND_W         = 3;
    localparam int INDEX_W        = 4;
    localparam int STATUS_W       = 2;
    localparam int NUM_TIMERS_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_FIRED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   now;
        logic [INDEX_W-1:0]  timer_index;
        logic [PERIOD_W-1:0] interval;
        logic                start_enabled;
    } ptt_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  timer_index_res;
        logic                last;
    } ptt_rsp_t;

    typedef struct packed {
        logic period;
        logic last_fire;
        logic active;
    } ptt_we_t;

endpackage

// ----- design/ptt_alu.sv -----
module ptt_alu (
    input  logic [ptt_pkg::TIME_W-1:0] a,
    input  logic [ptt_pkg::TIME_W-1:0] b,
    input  logic                       sub,
    output logic [ptt_pkg::TIME_W-1:0] y,
    output logic                       geq
);
    import ptt_pkg::*;

    logic [TIME_W-1:0] b_op;
    logic [TIME_W:0]   sum;

    // a - b as a + ~b + 1; carry out means a >= b
    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{TIME_W{1'b0}}, sub};
    assign y    = sum[TIME_W-1:0];
    assign geq  = sub & sum[TIME_W];

endmodule

// ----- design/ptt_table.sv -----
module ptt_table #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic                                               clk,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
    input  ptt_pkg::ptt_we_t                                   we,
    input  logic [ptt_pkg::PERIOD_W-1:0]                       wr_period,
    input  logic [ptt_pkg::TIME_W-1:0]                         wr_lf,
    input  logic                                               wr_active,
    output logic [ptt_pkg::PERIOD_W-1:0]                       rd_period,
    output logic [ptt_pkg::TIME_W-1:0]                         rd_lf,
    output logic                                               rd_active
);
    import ptt_pkg::*;

    logic [PERIOD_W-1:0] period_mem [NUM_TIMERS];
    logic [TIME_W-1:0]   lf_mem     [NUM_TIMERS];
    logic                active_mem [NUM_TIMERS];

    always_ff @(posedge clk)
    begin
        if (we.period)
        begin
            period_mem[wr_addr] <= wr_period;
        end
        if (we.last_fire)
        begin
            lf_mem[wr_addr] <= wr_lf;
        end
        if (we.active)
        begin
            active_mem[wr_addr] <= wr_active;
        end
        rd_period <= period_mem[rd_addr];
        rd_lf     <= lf_mem[rd_addr];
        rd_active <= active_mem[rd_addr];
    end

endmodule

// ----- design/periodic_timer_table_core.sv -----
// Periodic timer table. Requests add a timer (answered with its index or table full),
// change an entry's interval, enable it (restarting its period at req.now) or disable
// it; a bad index is answered with status 3. A tick request scans the allocated entries
// in index order and returns one "fired" response per due entry, the final one with
// last set; a tick with nothing due returns no response. One 64-bit add/compare unit
// is shared by all time arithmetic, so a tick handles one entry at a time and can also
// wait on output stalls. The block takes no new request until the current one has
// finished. Time wraps modulo 2^64.
module periodic_timer_table_core #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ptt_pkg::ptt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ptt_pkg::ptt_rsp_t rsp
);
    import ptt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_DUE   = 4'd4;
    localparam logic [3:0] S_FIRE  = 4'd5;
    localparam logic [3:0] S_DIFF  = 4'd6;
    localparam logic [3:0] S_M1    = 4'd7;
    localparam logic [3:0] S_M2    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_FLUSH = 4'd11;

    logic [3:0]          state_reg, state_next;
    ptt_req_t            req_reg, req_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [TIME_W-1:0]   lf_reg, lf_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic [TIME_W-1:0]   acc_reg, acc_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic                act_reg, act_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [INDEX_W-1:0]  pend_index_reg, pend_index_next;
    logic                rsp_valid_reg, rsp_valid_next;
    ptt_rsp_t            rsp_reg, rsp_next;

    logic [TIME_W-1:0]   alu_a, alu_b, alu_y;
    logic                alu_sub, alu_geq;

    logic [IDX_W-1:0]    rd_addr, wr_addr;
    ptt_we_t             we;
    logic [PERIOD_W-1:0] wr_period, rd_period;
    logic [TIME_W-1:0]   wr_lf, rd_lf;
    logic                wr_active, rd_active;

    logic [CMP_W-1:0]    idx_ext, used_ext, scan_ext;
    logic [CNT_W-1:0]    scan_inc;
    logic                idx_ok, full, can_push;

    assign idx_ext  = CMP_W'(req_reg.timer_index);
    assign used_ext = CMP_W'(used_reg);
    assign scan_ext = CMP_W'(scan_reg);
    assign scan_inc = scan_reg + CNT_W'(1);
    assign idx_ok   = idx_ext < used_ext;
    assign full     = used_reg == CNT_W'(NUM_TIMERS);
    assign can_push = !rsp_valid_reg || rsp_ready;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_addr   = scan_reg[IDX_W-1:0];

    ptt_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y),
        .geq (alu_geq)
    );

    ptt_table #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_table (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .we        (we),
        .wr_period (wr_period),
        .wr_lf     (wr_lf),
        .wr_active (wr_active),
        .rd_period (rd_period),
        .rd_lf     (rd_lf),
        .rd_active (rd_active)
    );

    // operand select for the shared unit
    always_comb
    begin
        alu_a   = req_reg.now;
        alu_b   = lf_reg;
        alu_sub = 1'b1;
        case (state_reg)
            S_SUM:
            begin
                alu_a   = rd_lf;
                alu_b   = {{(TIME_W-PERIOD_W){1'b0}}, rd_period};
                alu_sub = 1'b0;
            end
            S_M1:
            begin
                alu_a   = {1'b0, per_reg, 6'b0};
                alu_b   = {2'b0, per_reg, 5'b0};
                alu_sub = 1'b0;
            end
            S_M2:
            begin
                alu_a   = acc_reg;
                alu_b   = {5'b0, per_reg, 2'b0};
                alu_sub = 1'b0;
            end
            S_CMP:
            begin
                alu_a   = diff_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = req_reg.now;
                alu_b   = lf_reg;
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        used_next        = used_reg;
        scan_next        = scan_reg;
        lf_next          = lf_reg;
        diff_next        = diff_reg;
        acc_next         = acc_reg;
        per_next         = per_reg;
        act_next         = act_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;
        we               = '0;
        wr_addr          = scan_reg[IDX_W-1:0];
        wr_period        = req_reg.interval;
        wr_lf            = req_reg.now;
        wr_active        = req_reg.start_enabled;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (req_reg.kind)
                    KIND_TICK:
                    begin
                        scan_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = (used_reg == '0) ? S_IDLE : S_RD;
                    end
                    KIND_ADD:
                    begin
                        pend_valid_next = 1'b1;
                        state_next      = S_FLUSH;
                        if (full)
                        begin
                            pend_status_next = ST_FULL;
                            pend_index_next  = '0;
                        end
                        else
                        begin
                            we               = '{period: 1'b1, last_fire: 1'b1, active: 1'b1};
                            wr_addr          = used_reg[IDX_W-1:0];
                            used_next        = used_reg + CNT_W'(1);
                            pend_status_next = ST_DONE;
                            pend_index_next  = used_ext[INDEX_W-1:0];
                        end
                    end
                    KIND_SET, KIND_ENABLE, KIND_DISABLE:
                    begin
                        pend_valid_next = 1'b1;
                        pend_index_next = req_reg.timer_index;
                        state_next      = S_FLUSH;
                        if (!idx_ok)
                        begin
                            pend_status_next = ST_BADIDX;
                        end
                        else
                        begin
                            pend_status_next = ST_DONE;
                            wr_addr          = idx_ext[IDX_W-1:0];
                            case (req_reg.kind)
                                KIND_SET:
                                begin
                                    we.period = 1'b1;
                                end
                                KIND_ENABLE:
                                begin
                                    we.active    = 1'b1;
                                    we.last_fire = 1'b1;
                                    wr_active    = 1'b1;
                                end
                                default:
                                begin
                                    we.active = 1'b1;
                                    wr_active = 1'b0;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                lf_next    = alu_y;
                per_next   = rd_period;
                act_next   = rd_active;
                state_next = S_DUE;
            end
            S_DUE:
            begin
                state_next = (act_reg && alu_geq) ? S_FIRE : S_NEXT;
            end
            S_FIRE:
            begin
                // the previous fire is known not to be the final one now
                if (!pend_valid_reg || can_push)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{status: pend_status_reg,
                                           timer_index_res: pend_index_reg,
                                           last: 1'b0};
                    end
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_FIRED;
                    pend_index_next  = scan_ext[INDEX_W-1:0];
                    state_next       = S_DIFF;
                end
            end
            S_DIFF:
            begin
                diff_next  = alu_y;
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next   = alu_y;
                state_next = S_M2;
            end
            S_M2:
            begin
                // acc = period * 100 (mod 2^64)
                acc_next   = alu_y;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                we.last_fire = 1'b1;
                wr_lf        = alu_geq ? req_reg.now : lf_reg;
                state_next   = S_NEXT;
            end
            S_NEXT:
            begin
                scan_next  = scan_inc;
                state_next = (scan_inc == used_reg) ? S_FLUSH : S_RD;
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '{status: pend_status_reg,
                                        timer_index_res: pend_index_reg,
                                        last: 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        scan_reg        <= scan_next;
        lf_reg          <= lf_next;
        diff_reg        <= diff_next;
        acc_reg         <= acc_next;
        per_reg         <= per_next;
        act_reg         <= act_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        rsp_reg         <= rsp_next;
    end

endmodule
